// File: hdl/ats_pkg.sv
`timescale 1ns / 1ps

package ats_pkg;

	// defaults for the top-level parameters
	localparam int ADC_BITS_DEF    = 10;
	localparam int QUEUE_DEPTH_DEF = 4;

	// scale factors in hundredths: C = adc*110/100, F = adc*198/100
	localparam logic [7:0] FAC_C = 8'd110;
	localparam logic [7:0] FAC_F = 8'd198;
	// offsets in tenths of a degree
	localparam logic [9:0] OFF_C = 10'd500;
	localparam logic [9:0] OFF_F = 10'd580;

	// segment patterns, bit 7 is the decimal point
	localparam logic [7:0] SEG_DP = 8'h80;
	localparam logic [7:0] SYM_F  = 8'h71;
	localparam logic [7:0] SYM_C  = 8'h39;

	// display positions in emission order
	localparam logic [1:0] POS_HUND  = 2'd0;
	localparam logic [1:0] POS_TENS  = 2'd1;
	localparam logic [1:0] POS_UNITS = 2'd2;
	localparam logic [1:0] POS_SYM   = 2'd3;

	// one converted sample, as held in the queue
	typedef struct packed {
		logic       fahr;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] units;
	} ats_word_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h67;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// File: hdl/ats_front.sv
`timescale 1ns / 1ps

module ats_front #(
	parameter int ADC_BITS    = ats_pkg::ADC_BITS_DEF,
	parameter int QUEUE_DEPTH = ats_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ADC_BITS-1:0]   adc_sample,
	input  logic                  unit_pin,
	input  logic                  pop,
	output logic                  busy,
	output logic                  push,
	output ats_pkg::ats_word_t    push_word
);
	import ats_pkg::*;

	// widths
	localparam int SW    = ADC_BITS + 8;            // scaled sample
	localparam int K100  = ADC_BITS + 15;           // reciprocal shift for /100
	localparam int M100W = ADC_BITS + 9;
	localparam int PW    = SW + M100W;
	localparam int QW    = ADC_BITS + 2;            // tenths, also holds the offset
	localparam int K10   = QW + 5;                  // reciprocal shift for /10
	localparam int R10W  = QW + 2;
	localparam int Q1W   = QW - 3;
	localparam int Q2W   = QW - 6;
	localparam int Q3W   = QW - 9;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [M100W-1:0] R100 = M100W'(((64'd1 << K100) + 64'd99) / 64'd100);
	localparam logic [R10W-1:0]  R10  = R10W'(((64'd1 << K10) + 64'd9) / 64'd10);

	logic accept;
	logic [CW-1:0] cnt_q;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic [ADC_BITS-1:0]     adc_s1;
	logic                    fahr_s1, fahr_s2, fahr_s3, fahr_s4, fahr_s5, fahr_s6, fahr_s7, fahr_s8;
	logic [SW-1:0]           scaled_s2;
	logic [PW-1:0]           prod_s3;
	logic [QW-1:0]           t_s4, t_s5;
	logic [QW+R10W-1:0]      pq1_s5;
	logic [Q1W-1:0]          q1_s6;
	logic [3:0]              r0_s6, r0_s7, r0_s8;
	logic [Q1W+R10W-1:0]     pq2_s6;
	logic [Q2W-1:0]          q2_s7;
	logic [3:0]              r1_s7, r1_s8;
	logic [Q2W+R10W-1:0]     pq3_s7;
	logic [3:0]              r2_s8;

	// combinational
	logic [QW-1:0]  quot;
	logic [QW-1:0]  off;
	logic [QW-1:0]  t_c;
	logic [Q1W-1:0] q1_c;
	logic [Q2W-1:0] q2_c;
	logic [Q3W-1:0] q3_c;
	logic [QW-1:0]  r0_full;
	logic [Q1W-1:0] r1_full;
	logic [Q2W-1:0] r2_full;

	// credit count: samples taken but not yet popped from the queue
	assign busy   = (cnt_q == CW'(QUEUE_DEPTH));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && !pop) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (!accept && pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// offset subtract with floor at zero
	assign quot = prod_s3[PW-1:K100];
	assign off  = fahr_s3 ? QW'(OFF_F) : QW'(OFF_C);
	assign t_c  = (quot > off) ? (quot - off) : '0;

	// divide by ten through the reciprocal, remainder by back-multiply
	assign q1_c    = pq1_s5[QW+R10W-1:K10];
	assign r0_full = t_s5 - QW'(q1_c) * QW'(10);
	assign q2_c    = pq2_s6[Q1W+R10W-1:K10];
	assign r1_full = q1_s6 - Q1W'(q2_c) * Q1W'(10);
	assign q3_c    = pq3_s7[Q2W+R10W-1:K10];
	assign r2_full = q2_s7 - Q2W'(q3_c) * Q2W'(10);

	always_ff @(posedge clk) begin
		if (accept) begin
			adc_s1  <= adc_sample;
			fahr_s1 <= unit_pin;
		end
		scaled_s2 <= SW'(adc_s1) * SW'(fahr_s1 ? FAC_F : FAC_C);
		fahr_s2   <= fahr_s1;
		prod_s3   <= PW'(scaled_s2) * PW'(R100);
		fahr_s3   <= fahr_s2;
		t_s4      <= t_c;
		fahr_s4   <= fahr_s3;
		t_s5      <= t_s4;
		pq1_s5    <= (QW+R10W)'(t_s4) * (QW+R10W)'(R10);
		fahr_s5   <= fahr_s4;
		q1_s6     <= q1_c;
		r0_s6     <= r0_full[3:0];
		pq2_s6    <= (Q1W+R10W)'(q1_c) * (Q1W+R10W)'(R10);
		fahr_s6   <= fahr_s5;
		q2_s7     <= q2_c;
		r1_s7     <= r1_full[3:0];
		r0_s7     <= r0_s6;
		pq3_s7    <= (Q2W+R10W)'(q2_c) * (Q2W+R10W)'(R10);
		fahr_s7   <= fahr_s6;
		r2_s8     <= r2_full[3:0];
		r1_s8     <= r1_s7;
		r0_s8     <= r0_s7;
		fahr_s8   <= fahr_s7;
	end

	assign push            = v_s8;
	assign push_word.fahr  = fahr_s8;
	assign push_word.hund  = r2_s8;
	assign push_word.tens  = r1_s8;
	assign push_word.units = r0_s8;

	a_credit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("credit count above queue depth");

	a_no_pop_without_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop with no sample in flight");

endmodule

// File: hdl/ats_fifo.sv
`timescale 1ns / 1ps

module ats_fifo #(
	parameter int DEPTH = ats_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ats_pkg::ats_word_t wr_word,
	input  logic               pop,
	output logic               not_empty,
	output ats_pkg::ats_word_t rd_word
);
	import ats_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ats_word_t     mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign rd_word   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_word;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> cnt_q != CW'(DEPTH))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");

endmodule

// File: hdl/ats_back.sv
`timescale 1ns / 1ps

module ats_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  ats_pkg::ats_word_t rd_word,
	output logic               pop,
	output logic               valid,
	output logic [7:0]         segments,
	output logic [1:0]         digit_position,
	output logic               last
);
	import ats_pkg::*;

	logic      active_q;
	logic [1:0] pos_q;
	ats_word_t item_q;

	// take the next word when idle or as the current one shows its unit symbol
	assign pop = not_empty && (!active_q || pos_q == POS_SYM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= POS_HUND;
		end else if (pop) begin
			active_q <= 1'b1;
			pos_q    <= POS_HUND;
		end else if (active_q) begin
			if (pos_q == POS_SYM) begin
				active_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= rd_word;
		end
	end

	always_comb begin
		unique case (pos_q)
			POS_HUND:  segments = seg_of(item_q.hund);
			POS_TENS:  segments = seg_of(item_q.tens) | SEG_DP;
			POS_UNITS: segments = seg_of(item_q.units);
			POS_SYM:   segments = item_q.fahr ? SYM_F : SYM_C;
			default:   segments = 8'h00;
		endcase
	end

	assign valid          = active_q;
	assign digit_position = pos_q;
	assign last           = active_q && (pos_q == POS_SYM);

	a_digits_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && pos_q != POS_SYM) |=> (active_q && pos_q == $past(pos_q) + 2'd1))
		else $error("digit sequence broken");

endmodule

// File: hdl/adc_temperature_to_seven_segment.sv
`timescale 1ns / 1ps

// Channel   Handshake            Word
// -------   ------------------   --------------------------------------
// sample    start / busy         adc_sample, unit_pin
// result    valid (strobe only)  segments, digit_position, last
//
// Each sample gives four words on consecutive cycles: hundreds, tens with
// the point lit, units, unit symbol.  Sustained rate is set by the back end
// showing one digit per cycle.
// Up to QUEUE_DEPTH samples are taken back to back; busy rises when that
// many are in flight and falls as the back end picks the next one up.
// With the back end idle, a sample passes the front pipeline registers, the queue
// and the back end's item register before its first word is on the ports.
// arst_n clears the pipeline valids, credit count, queue pointers and digit sequencer.
// The receiver cannot stall: a word is on the ports for one cycle only.

module adc_temperature_to_seven_segment #(
	parameter int ADC_BITS    = ats_pkg::ADC_BITS_DEF,
	parameter int QUEUE_DEPTH = ats_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ADC_BITS-1:0] adc_sample,
	input  logic                unit_pin,
	output logic                valid,
	output logic [7:0]          segments,
	output logic [1:0]          digit_position,
	output logic                last
);
	import ats_pkg::*;

	logic      push;
	logic      pop;
	logic      not_empty;
	ats_word_t push_word;
	ats_word_t rd_word;

	// front: scale, offset, floor at zero, split into decimal digits
	ats_front #(
		.ADC_BITS    (ADC_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.adc_sample (adc_sample),
		.unit_pin   (unit_pin),
		.pop        (pop),
		.busy       (busy),
		.push       (push),
		.push_word  (push_word)
	);

	// queue of converted samples; credits in the front keep it from overflowing
	ats_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_word   (push_word),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_word   (rd_word)
	);

	// back: walk the four display positions, one word per cycle
	ats_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.not_empty      (not_empty),
		.rd_word        (rd_word),
		.pop            (pop),
		.valid          (valid),
		.segments       (segments),
		.digit_position (digit_position),
		.last           (last)
	);

endmodule
